### hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BPC_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error("assertion failed");
`define BPC_ASSERT_ALWAYS(lbl, clk_s, prop) \
    lbl: assert property (@(posedge clk_s) prop) \
        else $error("assertion failed");
`else
`define BPC_ASSERT(lbl, clk_s, rstn_s, prop)
`define BPC_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

### hw/rtl/bpc_pkg.sv
// shared widths and arithmetic helpers for the pressure compensation block
package bpc_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DATA_W + 1);
    localparam int RAW_W  = 19;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_CALIB_A = 2'd0;
    localparam logic [IDX_W-1:0] REG_CALIB_B = 2'd1;
    localparam logic [IDX_W-1:0] REG_CALIB_C = 2'd2;
    localparam logic [IDX_W-1:0] REG_OSS     = 2'd3;

    typedef logic [DATA_W-1:0] word_t;

    typedef struct packed {
        logic  done;
        logic  busy;
    } div_status_t;

    function automatic word_t asr(input word_t a, input logic [4:0] k);
        return word_t'($signed(a) >>> k);
    endfunction

    // signed division by 2**k, truncating toward zero
    function automatic word_t sdiv_pow2(input word_t a, input logic [4:0] k);
        word_t bias;
        bias = a[DATA_W-1] ? ((word_t'(1) << k) - word_t'(1)) : '0;
        return asr(a + bias, k);
    endfunction

    function automatic word_t sx16(input logic [15:0] v);
        return {{(DATA_W-16){v[15]}}, v};
    endfunction

endpackage

### hw/rtl/bpc_mul.sv
// shared 32 by 32 multiplier keeping the low word, registered
module bpc_mul (
    input  logic           clk,
    input  bpc_pkg::word_t a,
    input  bpc_pkg::word_t b,
    output bpc_pkg::word_t prod
);
    import bpc_pkg::*;

    word_t prod_reg;
    word_t prod_next;

    always_comb
    begin
        prod_next = word_t'(a * b);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

### hw/rtl/bpc_div.sv
// unsigned restoring divider, one quotient bit per cycle
module bpc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  bpc_pkg::word_t      dividend,
    input  bpc_pkg::word_t      divisor,
    output bpc_pkg::word_t      quotient,
    output bpc_pkg::div_status_t status
);
    import bpc_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    word_t            quo_reg, quo_next;
    word_t            rem_reg, rem_next;
    word_t            dsr_reg, dsr_next;
    logic [DATA_W:0]  shifted;
    logic [DATA_W:0]  diff;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DATA_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient    = quo_reg;
    assign status.done = done_reg;
    assign status.busy = busy_reg;

endmodule

### hw/rtl/barometric_pressure_compensation_unit.sv
// top level: sequencer, register file and output stage of the compensation unit
//
// usage
// - input stream s_*: one request per conversion; s_tuser holds the opcode and
//   s_tdata holds raw_value (bits 18:0); opcode 0 compensates temperature, 1 pressure
// - output stream m_*: one result per request; m_tdata holds the signed value and
//   m_tuser holds div_error
// - cfg_we/cfg_index/cfg_data write calib_a, calib_b, calib_c, oversampling
//   while the unit is idle
// - one shared multiplier and one radix-2 divider do all the work under a
//   sequencer; a zero divisor skips the divider and gives a zero result with
//   div_error set
// - one request is in flight at a time; s_tready is high only while idle, so
//   a new request is not accepted until the previous result leaves the sequencer
// - a finished result waits in the output register; a new request can be
//   accepted while it waits, and the next result holds in the sequencer
//   until the output register frees
// - reset clears calibration, oversampling and the stored b5 to zero
module barometric_pressure_compensation_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic                       s_tuser,   // opcode
    input  logic [23:0]                s_tdata,   // raw_value, zero pad
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // value
    output logic                       m_tuser,   // div_error
    input  logic                       cfg_we,
    input  logic [bpc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [bpc_pkg::CFG_W-1:0]  cfg_data
);
    import bpc_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_T0   = 5'd1;
    localparam logic [4:0] ST_T1   = 5'd2;
    localparam logic [4:0] ST_T2   = 5'd3;
    localparam logic [4:0] ST_TDIV = 5'd4;
    localparam logic [4:0] ST_T3   = 5'd5;
    localparam logic [4:0] ST_P0   = 5'd6;
    localparam logic [4:0] ST_P1   = 5'd7;
    localparam logic [4:0] ST_P2   = 5'd8;
    localparam logic [4:0] ST_P3   = 5'd9;
    localparam logic [4:0] ST_P4   = 5'd10;
    localparam logic [4:0] ST_P5   = 5'd11;
    localparam logic [4:0] ST_P6   = 5'd12;
    localparam logic [4:0] ST_P7   = 5'd13;
    localparam logic [4:0] ST_P8   = 5'd14;
    localparam logic [4:0] ST_P9   = 5'd15;
    localparam logic [4:0] ST_P10  = 5'd16;
    localparam logic [4:0] ST_PDIV = 5'd17;
    localparam logic [4:0] ST_P11  = 5'd18;
    localparam logic [4:0] ST_P12  = 5'd19;
    localparam logic [4:0] ST_P13  = 5'd20;
    localparam logic [4:0] ST_P14  = 5'd21;
    localparam logic [4:0] ST_P15  = 5'd22;
    localparam logic [4:0] ST_DONE = 5'd23;

    localparam logic OP_TEMP  = 1'b0;

    logic [CFG_W-1:0]  calib_a_reg, calib_b_reg;
    logic [31:0]       calib_c_reg;
    logic [1:0]        oss_reg;
    word_t             ti_reg, ti_next;
    logic [4:0]        state_reg, state_next;
    logic [RAW_W-1:0]  raw_reg, raw_next;
    word_t             a_reg, a_next, b_reg, b_next, c_reg, c_next;
    word_t             res_reg, res_next;
    logic              err_reg, err_next;
    logic              neg_reg, neg_next;
    logic              out_valid_reg, out_valid_next;
    word_t             out_value_reg, out_value_next;
    logic              out_err_reg, out_err_next;

    word_t             ac1, ac2, ac3, ac4, ac5, ac6, cb1, cb2, mc, md;
    word_t             b6, raw_w, t_dvd, t_dsr, x3;
    word_t             mul_a, mul_b, mul_res;
    logic              div_start;
    word_t             div_dvd, div_dsr, div_quo;
    div_status_t       div_stat;
    logic              slot_free;

    assign ac1   = sx16(calib_a_reg[63:48]);
    assign ac2   = sx16(calib_a_reg[47:32]);
    assign ac3   = sx16(calib_a_reg[31:16]);
    assign ac4   = word_t'(calib_a_reg[15:0]);
    assign ac5   = word_t'(calib_b_reg[63:48]);
    assign ac6   = word_t'(calib_b_reg[47:32]);
    assign cb1   = sx16(calib_b_reg[31:16]);
    assign cb2   = sx16(calib_b_reg[15:0]);
    assign mc    = sx16(calib_c_reg[31:16]);
    assign md    = sx16(calib_c_reg[15:0]);
    assign b6    = ti_reg - word_t'(4000);
    assign raw_w = word_t'(raw_reg);
    assign t_dvd = mc << 11;
    assign t_dsr = a_reg + md;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    bpc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_res)
    );

    bpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .quotient (div_quo),
        .status   (div_stat)
    );

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_T0:
            begin
                mul_a = raw_w - ac6;
                mul_b = ac5;
            end
            ST_P0:
            begin
                mul_a = b6;
                mul_b = b6;
            end
            ST_P2:
            begin
                mul_a = cb2;
                mul_b = a_reg;
            end
            ST_P3:
            begin
                mul_a = ac2;
                mul_b = b6;
            end
            ST_P4:
            begin
                mul_a = ac3;
                mul_b = b6;
            end
            ST_P5:
            begin
                mul_a = cb1;
                mul_b = a_reg;
            end
            ST_P7:
            begin
                mul_a = ac4;
                mul_b = c_reg + word_t'(32768);
            end
            ST_P8:
            begin
                mul_a = raw_w - b_reg;
                mul_b = word_t'(50000) >> oss_reg;
            end
            ST_P11:
            begin
                mul_a = asr(a_reg, 5'd8);
                mul_b = asr(a_reg, 5'd8);
            end
            ST_P12:
            begin
                mul_a = mul_res;
                mul_b = word_t'(3038);
            end
            ST_P13:
            begin
                mul_a = word_t'(-32'sd7357);
                mul_b = a_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        raw_next       = raw_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        res_next       = res_reg;
        err_next       = err_reg;
        neg_next       = neg_reg;
        ti_next        = ti_reg;
        div_start      = 1'b0;
        div_dvd        = '0;
        div_dsr        = '0;
        x3             = '0;
        out_valid_next = out_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    raw_next   = s_tdata[RAW_W-1:0];
                    err_next   = 1'b0;
                    res_next   = '0;
                    state_next = (s_tuser == OP_TEMP) ? ST_T0 : ST_P0;
                end
            end
            ST_T0:
                state_next = ST_T1;
            ST_T1:
            begin
                a_next     = sdiv_pow2(mul_res, 5'd15);
                state_next = ST_T2;
            end
            ST_T2:
            begin
                if (t_dsr == '0)
                begin
                    err_next   = 1'b1;
                    res_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_dvd    = t_dvd[DATA_W-1] ? (word_t'(0) - t_dvd) : t_dvd;
                    div_dsr    = t_dsr[DATA_W-1] ? (word_t'(0) - t_dsr) : t_dsr;
                    neg_next   = t_dvd[DATA_W-1] ^ t_dsr[DATA_W-1];
                    state_next = ST_TDIV;
                end
            end
            ST_TDIV:
            begin
                if (div_stat.done)
                begin
                    b_next     = neg_reg ? (word_t'(0) - div_quo) : div_quo;
                    state_next = ST_T3;
                end
            end
            ST_T3:
            begin
                ti_next    = a_reg + b_reg;
                res_next   = sdiv_pow2(a_reg + b_reg + word_t'(8), 5'd4);
                state_next = ST_DONE;
            end
            ST_P0:
                state_next = ST_P1;
            ST_P1:
            begin
                a_next     = asr(mul_res, 5'd12);
                state_next = ST_P2;
            end
            ST_P2:
                state_next = ST_P3;
            ST_P3:
            begin
                b_next     = asr(mul_res, 5'd11);
                state_next = ST_P4;
            end
            ST_P4:
            begin
                x3         = b_reg + asr(mul_res, 5'd11);
                b_next     = asr((((ac1 << 2) + x3) << oss_reg) + word_t'(2), 5'd2);
                state_next = ST_P5;
            end
            ST_P5:
            begin
                c_next     = asr(mul_res, 5'd13);
                state_next = ST_P6;
            end
            ST_P6:
            begin
                c_next     = asr(c_reg + asr(mul_res, 5'd16) + word_t'(2), 5'd2);
                state_next = ST_P7;
            end
            ST_P7:
                state_next = ST_P8;
            ST_P8:
            begin
                c_next     = mul_res >> 15;
                state_next = ST_P9;
            end
            ST_P9:
            begin
                a_next     = mul_res;
                state_next = ST_P10;
            end
            ST_P10:
            begin
                if (c_reg == '0)
                begin
                    err_next   = 1'b1;
                    res_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_dvd    = a_reg[DATA_W-1] ? a_reg : (a_reg << 1);
                    div_dsr    = c_reg;
                    state_next = ST_PDIV;
                end
            end
            ST_PDIV:
            begin
                if (div_stat.done)
                begin
                    a_next     = a_reg[DATA_W-1] ? (div_quo << 1) : div_quo;
                    state_next = ST_P11;
                end
            end
            ST_P11:
                state_next = ST_P12;
            ST_P12:
                state_next = ST_P13;
            ST_P13:
            begin
                b_next     = asr(mul_res, 5'd16);
                state_next = ST_P14;
            end
            ST_P14:
            begin
                c_next     = b_reg + asr(mul_res, 5'd16) + word_t'(3791);
                state_next = ST_P15;
            end
            ST_P15:
            begin
                res_next   = a_reg + sdiv_pow2(c_reg, 5'd4);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    out_err_next   = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_a_reg   <= '0;
            calib_b_reg   <= '0;
            calib_c_reg   <= '0;
            oss_reg       <= '0;
            ti_reg        <= '0;
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CALIB_A: calib_a_reg <= cfg_data;
                    REG_CALIB_B: calib_b_reg <= cfg_data;
                    REG_CALIB_C: calib_c_reg <= cfg_data[31:0];
                    REG_OSS:     oss_reg     <= cfg_data[1:0];
                    default:     oss_reg     <= oss_reg;
                endcase
            end
            ti_reg        <= ti_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg       <= raw_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        c_reg         <= c_next;
        res_reg       <= res_next;
        err_reg       <= err_next;
        neg_reg       <= neg_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_err_reg;

    `include "assert_macros.svh"

    `BPC_ASSERT(a_div_done_state, clk, rst_n, div_stat.done |-> (state_reg == ST_TDIV || state_reg == ST_PDIV))
    `BPC_ASSERT(a_out_from_done, clk, rst_n, $rose(m_tvalid) |-> $past(state_reg) == ST_DONE)
    `BPC_ASSERT(a_err_zero_value, clk, rst_n, (m_tvalid && m_tuser) |-> (m_tdata == 32'd0))

endmodule

### bench/tb.sv
// self-checking bench for the barometric pressure compensation unit
module tb;
    import bpc_pkg::*;

    typedef enum logic
    {
        OP_TEMPERATURE = 1'b0,
        OP_PRESSURE    = 1'b1
    } opcode_e;

    typedef struct packed
    {
        logic [31:0] value;
        logic        div_error;
    } reading_t;

    typedef struct
    {
        bit                is_write;
        logic [IDX_W-1:0]  reg_idx;
        logic [CFG_W-1:0]  reg_data;
        opcode_e           op;
        logic [RAW_W-1:0]  raw;
        bit                typed;
        logic [31:0]       want_value;
        bit                want_err;
    } stim_row_t;

    localparam int RANDOM_ITEMS  = 1850;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int DIRECTED_ROWS = 36;
    localparam logic [RAW_W-1:0] RAW_MAX = '1;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic              s_tuser;   // opcode
    logic [23:0]       s_tdata;   // raw_value, zero pad
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;   // value
    logic              m_tuser;   // div_error
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    // predictor copy of the registers and the stored b5
    logic [63:0] cal_a;
    logic [63:0] cal_b;
    logic [31:0] cal_c;
    logic [1:0]  oss_setting;
    logic [31:0] stored_b5;

    reading_t pending_results [$];
    int       mismatch_count;
    int       cycle_count;
    int       random_sent;
    bit       idle_on;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // after reset every divisor is zero
        '{1'b0, REG_CALIB_A, 64'd0, OP_TEMPERATURE, 19'd0,   1'b1, 32'd0, 1'b1},
        '{1'b0, REG_CALIB_A, 64'd0, OP_TEMPERATURE, RAW_MAX, 1'b1, 32'd0, 1'b1},
        '{1'b0, REG_CALIB_A, 64'd0, OP_PRESSURE,    19'd0,   1'b1, 32'd0, 1'b1},
        '{1'b0, REG_CALIB_A, 64'd0, OP_PRESSURE,    RAW_MAX, 1'b1, 32'd0, 1'b1},
        // typical factory calibration
        '{1'b1, REG_CALIB_A, 64'h0198_FFB8_C7D1_7FE5, OP_TEMPERATURE, 19'd0, 1'b0, 32'd0, 1'b0},
        '{1'b1, REG_CALIB_B, 64'h7FF5_5A71_182E_0004, OP_TEMPERATURE, 19'd0, 1'b0, 32'd0, 1'b0},
        '{1'b1, REG_CALIB_C, 64'h0000_0000_DDF9_0B34, OP_TEMPERATURE, 19'd0, 1'b0, 32'd0, 1'b0},
        '{1'b1, REG_OSS,     64'd0, OP_TEMPERATURE, 19'd0,    1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_TEMPERATURE, 19'd27898, 1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_PRESSURE,    19'd23843, 1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_PRESSURE,    19'd0,     1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_PRESSURE,    RAW_MAX,   1'b0, 32'd0, 1'b0},
        '{1'b1, REG_OSS,     64'd3, OP_TEMPERATURE, 19'd0,     1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_PRESSURE,    19'd23843, 1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_TEMPERATURE, 19'd0,     1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_TEMPERATURE, RAW_MAX,   1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_PRESSURE,    RAW_MAX,   1'b0, 32'd0, 1'b0},
        // md cancels x1: temperature divisor zero, b5 must survive
        '{1'b1, REG_CALIB_C, 64'h0000_0000_DDF9_ED79, OP_TEMPERATURE, 19'd0, 1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_TEMPERATURE, 19'd27898, 1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_PRESSURE,    19'd23843, 1'b0, 32'd0, 1'b0},
        // all-ones calibration
        '{1'b1, REG_CALIB_A, '1, OP_TEMPERATURE, 19'd0, 1'b0, 32'd0, 1'b0},
        '{1'b1, REG_CALIB_B, '1, OP_TEMPERATURE, 19'd0, 1'b0, 32'd0, 1'b0},
        '{1'b1, REG_CALIB_C, 64'h0000_0000_FFFF_FFFF, OP_TEMPERATURE, 19'd0, 1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_TEMPERATURE, 19'd0,   1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_PRESSURE,    RAW_MAX, 1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_TEMPERATURE, RAW_MAX, 1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_PRESSURE,    19'd0,   1'b0, 32'd0, 1'b0},
        // signed extremes in every coefficient
        '{1'b1, REG_CALIB_A, 64'h7FFF_8000_7FFF_FFFF, OP_TEMPERATURE, 19'd0, 1'b0, 32'd0, 1'b0},
        '{1'b1, REG_CALIB_B, 64'hFFFF_FFFF_8000_7FFF, OP_TEMPERATURE, 19'd0, 1'b0, 32'd0, 1'b0},
        '{1'b1, REG_CALIB_C, 64'h0000_0000_8000_7FFF, OP_TEMPERATURE, 19'd0, 1'b0, 32'd0, 1'b0},
        '{1'b1, REG_OSS,     64'd1, OP_TEMPERATURE, 19'd0,   1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_TEMPERATURE, RAW_MAX, 1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_PRESSURE,    RAW_MAX, 1'b0, 32'd0, 1'b0},
        '{1'b1, REG_OSS,     64'd2, OP_TEMPERATURE, 19'd0,   1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_TEMPERATURE, 19'd0,   1'b0, 32'd0, 1'b0},
        '{1'b0, REG_CALIB_A, 64'd0, OP_PRESSURE,    19'd0,   1'b0, 32'd0, 1'b0}
    };

    barometric_pressure_compensation_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [31:0] widen_s16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] shift_down(input logic [31:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    // signed quotient truncated toward zero, divisor known non-zero
    function automatic logic [31:0] quot_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] mq;
        ma = a[31] ? 32'd0 - a : a;
        mb = b[31] ? 32'd0 - b : b;
        mq = ma / mb;
        return (a[31] != b[31]) ? 32'd0 - mq : mq;
    endfunction

    function automatic reading_t compensate_reading(input opcode_e op,
                                                    input logic [RAW_W-1:0] raw);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] reading, x1, x2, x3, divisor, b6, sq, b3, b4, b7, p, t;
        reading_t    res;
        ac1 = widen_s16(cal_a[63:48]);
        ac2 = widen_s16(cal_a[47:32]);
        ac3 = widen_s16(cal_a[31:16]);
        ac4 = {16'd0, cal_a[15:0]};
        ac5 = {16'd0, cal_b[63:48]};
        ac6 = {16'd0, cal_b[47:32]};
        b1  = widen_s16(cal_b[31:16]);
        b2  = widen_s16(cal_b[15:0]);
        mc  = widen_s16(cal_c[31:16]);
        md  = widen_s16(cal_c[15:0]);
        reading = {13'd0, raw};
        res.value = 32'd0;
        res.div_error = 1'b0;
        if (op == OP_TEMPERATURE)
        begin
            x1 = quot_trunc((reading - ac6) * ac5, 32'd32768);
            divisor = x1 + md;
            if (divisor == 32'd0)
                res.div_error = 1'b1;
            else
            begin
                x2 = quot_trunc(mc * 32'd2048, divisor);
                stored_b5 = x1 + x2;
                res.value = quot_trunc(stored_b5 + 32'd8, 32'd16);
            end
        end
        else
        begin
            b6 = stored_b5 - 32'd4000;
            sq = shift_down(b6 * b6, 12);
            x1 = shift_down(b2 * sq, 11);
            x2 = shift_down(ac2 * b6, 11);
            x3 = x1 + x2;
            b3 = (ac1 * 32'd4 + x3) << oss_setting;
            b3 = shift_down(b3 + 32'd2, 2);
            x1 = shift_down(ac3 * b6, 13);
            x2 = shift_down(b1 * sq, 16);
            x3 = shift_down(x1 + x2 + 32'd2, 2);
            b4 = (ac4 * (x3 + 32'd32768)) >> 15;
            b7 = (reading - b3) * (32'd50000 >> oss_setting);
            if (b4 == 32'd0)
                res.div_error = 1'b1;
            else
            begin
                if (b7 < 32'h8000_0000)
                    p = (b7 * 32'd2) / b4;
                else
                    p = (b7 / b4) * 32'd2;
                t  = shift_down(p, 8);
                x1 = t * t;
                x1 = shift_down(x1 * 32'd3038, 16);
                x2 = shift_down((32'd0 - 32'd7357) * p, 16);
                res.value = p + quot_trunc(x1 + x2 + 32'd3791, 32'd16);
            end
        end
        return res;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_CALIB_A: cal_a = data;
            REG_CALIB_B: cal_b = data;
            REG_CALIB_C: cal_c = data[31:0];
            REG_OSS:     oss_setting = data[1:0];
            default:     ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // every request gives one result, so an empty store means idle
    task automatic settle_block();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic send_request(input opcode_e op, input logic [RAW_W-1:0] raw,
                                input bit typed, input logic [31:0] want_value,
                                input bit want_err);
        int       gap;
        reading_t want;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, raw};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        want = compensate_reading(op, raw);
        if (typed)
        begin
            want.value = want_value;
            want.div_error = want_err;
        end
        pending_results.push_back(want);
    endtask

    task automatic check_reading(input logic [31:0] beat_value, input logic beat_err);
        reading_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result value %0d div_error %0b",
                     $time, $signed(beat_value), beat_err);
            mismatch_count++;
        end
        else
        begin
            want = pending_results.pop_front();
            if (beat_value !== want.value)
            begin
                $display("%0t: value expected %0d got %0d",
                         $time, $signed(want.value), $signed(beat_value));
                mismatch_count++;
            end
            if (beat_err !== want.div_error)
            begin
                $display("%0t: div_error expected %0b got %0b",
                         $time, want.div_error, beat_err);
                mismatch_count++;
            end
        end
    endtask

    function automatic logic [15:0] near(input logic [15:0] base);
        logic [15:0] j;
        j = 16'($urandom_range(0, 1023));
        return base + j - 16'd512;
    endfunction

    task automatic load_random_calibration();
        int          mode;
        logic [63:0] a_word, b_word, c_word;
        mode = $urandom_range(0, 9);
        a_word = {near(16'd408), near(16'hFFB8), near(16'hC7D1), near(16'd32741)};
        b_word = {near(16'd32757), near(16'd23153), near(16'd6190), near(16'd4)};
        c_word = {32'd0, near(16'hDDF9), near(16'd2868)};
        if (mode == 6 || mode == 7)
        begin
            a_word = {$urandom, $urandom};
            b_word = {$urandom, $urandom};
            c_word = {32'd0, $urandom};
        end
        else if (mode == 8)
            a_word[15:0] = 16'd0;
        else if (mode == 9)
        begin
            a_word = $urandom_range(0, 1) ? '1 : '0;
            b_word = $urandom_range(0, 1) ? '1 : '0;
            c_word = $urandom_range(0, 1) ? 64'h0000_0000_FFFF_FFFF : '0;
        end
        write_reg(REG_CALIB_A, a_word);
        write_reg(REG_CALIB_B, b_word);
        write_reg(REG_CALIB_C, c_word);
        write_reg(REG_OSS, 64'($urandom_range(0, 3)));
    endtask

    task automatic random_phase();
        int               phase_len;
        int               done_here;
        int               k;
        int               burst;
        logic [RAW_W-1:0] raw;
        phase_len = $urandom_range(40, 120);
        done_here = 0;
        while (done_here < phase_len && random_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                // noise request
                send_request(opcode_e'($urandom_range(0, 1)), RAW_W'($urandom), 1'b0, 0, 1'b0);
                done_here++;
                random_sent++;
            end
            else
            begin
                // temperature then a burst of pressure requests
                raw = ($urandom_range(0, 4) != 0) ? RAW_W'($urandom_range(15000, 45000))
                                                  : RAW_W'($urandom);
                send_request(OP_TEMPERATURE, raw, 1'b0, 0, 1'b0);
                burst = $urandom_range(1, 4);
                for (k = 0; k < burst; k++)
                begin
                    raw = $urandom_range(0, 1) ? RAW_W'($urandom_range(16000, 45000) << oss_setting)
                                               : RAW_W'($urandom);
                    send_request(OP_PRESSURE, raw, 1'b0, 0, 1'b0);
                end
                done_here += burst + 1;
                random_sent += burst + 1;
            end
        end
    endtask

    // result side with random stalls while idle_on is set
    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_tvalid !== 1'b1);
            check_reading(m_tdata, m_tuser);
        end
    end

    initial
    begin
        int r;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = 1'b0;
        s_tdata     = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cal_a       = '0;
        cal_b       = '0;
        cal_c       = '0;
        oss_setting = '0;
        stored_b5   = '0;
        mismatch_count = 0;
        cycle_count = 0;
        random_sent = 0;
        idle_on     = 1'b1;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed_rows[r].is_write)
            begin
                settle_block();
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_data);
            end
            else
                send_request(directed_rows[r].op, directed_rows[r].raw, directed_rows[r].typed,
                             directed_rows[r].want_value, directed_rows[r].want_err);
        end

        while (random_sent < RANDOM_ITEMS)
        begin
            settle_block();
            load_random_calibration();
            idle_on = ($urandom_range(0, 3) != 0);
            random_phase();
        end

        settle_block();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
